>>> rtl/core/u8d_pkg.sv
// Shared types, codes and helper functions of the UTF-8 stream decoder.
`default_nettype none
package u8d_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam int CP_W    = 31;
  localparam int STAT_W  = 2;
  localparam int CNT_W   = 3;
  localparam int IN_W    = 8;
  localparam int OUT_W   = 40;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_LEAD = 2'd1,
    ST_BAD_CONT = 2'd2,
    ST_OVERLONG = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    KIND_ASCII = 2'd0,
    KIND_CONT  = 2'd1,
    KIND_LEAD  = 2'd2,
    KIND_BAD   = 2'd3
  } kind_t;

  // One classified input byte.
  typedef struct packed {
    kind_t      kind;
    logic [2:0] extra;
    logic [6:0] payload;
  } entry_t;

  typedef struct packed {
    logic [CP_W-1:0]   code_point;
    status_t           status;
    logic [CNT_W-1:0]  byte_count;
  } result_t;

  function automatic logic [3:0] lead_ones(input logic [7:0] b);
    logic [3:0] n;
    logic       run;
    n   = 4'd0;
    run = 1'b1;
    for (int i = 7; i >= 0; i--) begin
      if (run && b[i]) begin
        n = n + 4'd1;
      end else begin
        run = 1'b0;
      end
    end
    return n;
  endfunction

  // Largest value of a character of idx+1 bytes.
  function automatic logic [CP_W-1:0] range_top(input logic [2:0] idx);
    logic [CP_W-1:0] r;
    case (idx)
      3'd0:    r = 31'h0000007f;
      3'd1:    r = 31'h000007ff;
      3'd2:    r = 31'h0000ffff;
      3'd3:    r = 31'h001fffff;
      3'd4:    r = 31'h03ffffff;
      default: r = 31'h7fffffff;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/utf8_stream_decoder_core.sv
// Top level of the six-byte UTF-8 stream decoder.
// Takes one raw byte per item and returns at most one result per byte: a code point with
// its length on ASCII or a complete sequence, or an error status with its offset. Sustained
// rate is one byte per cycle on both sides while neither side stalls; a byte passes a
// classify register, the entry queue (QueueDepth entries) and the decode/output register,
// in that order. The queue lets the byte side keep going while the result side is held
// for up to QueueDepth plus one items.
`default_nettype none
module utf8_stream_decoder_core #(
  parameter int QueueDepth = u8d_pkg::QUEUE_DEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [7:0]   s_tdata,   // byte_in[7:0]
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [39:0]       m_tdata    // code_point[30:0], status[32:31], byte_count[35:33]
);

  logic                             push;
  logic                             push_ready;
  u8d_pkg::entry_t                  push_entry;
  logic                             pop_valid;
  logic                             pop;
  u8d_pkg::entry_t                  pop_entry;
  logic [$clog2(QueueDepth+1)-1:0]  level;
  u8d_pkg::result_t                 result;

  u8d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .push       (push),
    .push_entry (push_entry),
    .push_ready (push_ready)
  );

  u8d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry),
    .pop        (pop),
    .level      (level)
  );

  u8d_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_entry (pop_entry),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .result    (result)
  );

  assign m_tdata = {4'd0, result.byte_count, result.status, result.code_point};

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= ($clog2(QueueDepth+1))'(QueueDepth))
    else $error("queue level above depth");

  a_err_no_cp: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && result.status != u8d_pkg::ST_OK |-> result.code_point == '0)
    else $error("error result carries a code point");

  a_ok_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && result.status == u8d_pkg::ST_OK |->
      result.byte_count != 3'd0 && result.byte_count != 3'd7)
    else $error("ok result with bad length");

  a_lead_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && result.status == u8d_pkg::ST_BAD_LEAD |-> result.byte_count == 3'd0)
    else $error("bad lead with nonzero offset");

endmodule
`default_nettype wire

>>> rtl/core/u8d_front.sv
// Front stage: accept raw bytes and classify them into queue entries.
`default_nettype none
module u8d_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [7:0]    s_tdata,
  output logic               push,
  output u8d_pkg::entry_t    push_entry,
  input  wire logic          push_ready
);

  logic            f_valid;
  u8d_pkg::entry_t f_entry;
  u8d_pkg::entry_t f_entry_next;
  logic [3:0]      ones;

  always_comb begin
    ones                 = u8d_pkg::lead_ones(s_tdata);
    f_entry_next.extra   = 3'(ones - 4'd1);
    f_entry_next.payload = 7'd0;
    if (ones == 4'd0) begin
      f_entry_next.kind    = u8d_pkg::KIND_ASCII;
      f_entry_next.payload = s_tdata[6:0];
    end else if (ones == 4'd1) begin
      f_entry_next.kind    = u8d_pkg::KIND_CONT;
      f_entry_next.payload = {1'b0, s_tdata[5:0]};
    end else if (ones > 4'd6) begin
      f_entry_next.kind    = u8d_pkg::KIND_BAD;
    end else begin
      f_entry_next.kind    = u8d_pkg::KIND_LEAD;
      f_entry_next.payload = s_tdata[6:0] & (7'h7f >> ones);
    end
  end

  assign s_tready   = !f_valid || push_ready;
  assign push       = f_valid && push_ready;
  assign push_entry = f_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (s_tready) begin
      f_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      f_entry <= f_entry_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/u8d_queue.sv
// Short FIFO of classified entries between front and back.
`default_nettype none
module u8d_queue #(
  parameter int Depth = u8d_pkg::QUEUE_DEPTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  wire u8d_pkg::entry_t        push_entry,
  output logic                        push_ready,
  output logic                        pop_valid,
  output u8d_pkg::entry_t             pop_entry,
  input  wire logic                   pop,
  output logic [$clog2(Depth+1)-1:0]  level
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int LW = $clog2(Depth + 1);

  u8d_pkg::entry_t mem [Depth];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [LW-1:0]   count;

  assign push_ready = count != LW'(Depth);
  assign pop_valid  = count != '0;
  assign pop_entry  = mem[rd_ptr];
  assign level      = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + LW'(1);
      end else if (pop && !push) begin
        count <= count - LW'(1);
      end
    end
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/u8d_back.sv
// Back stage: sequence state, overlong check and output register.
`default_nettype none
module u8d_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              pop_valid,
  input  wire u8d_pkg::entry_t   pop_entry,
  output logic                   pop,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output u8d_pkg::result_t       result
);

  logic [2:0]                  bytes_left;
  logic [2:0]                  extra_total;
  logic [u8d_pkg::CP_W-1:0]    accumulated;
  logic [2:0]                  bytes_left_next;
  logic [2:0]                  extra_total_next;
  logic [u8d_pkg::CP_W-1:0]    accumulated_next;
  logic                        emit;
  u8d_pkg::result_t            result_next;
  logic [u8d_pkg::CP_W-1:0]    acc_shift;
  logic                        advance;

  assign advance   = !m_tvalid || m_tready;
  assign pop       = pop_valid && advance;
  assign acc_shift = {accumulated[u8d_pkg::CP_W-7:0], pop_entry.payload[5:0]};

  always_comb begin
    bytes_left_next  = bytes_left;
    extra_total_next = extra_total;
    accumulated_next = accumulated;
    emit             = 1'b0;
    result_next      = '0;
    if (bytes_left == 3'd0) begin
      case (pop_entry.kind)
        u8d_pkg::KIND_ASCII: begin
          emit                   = 1'b1;
          result_next.code_point = u8d_pkg::CP_W'(pop_entry.payload);
          result_next.status     = u8d_pkg::ST_OK;
          result_next.byte_count = 3'd1;
        end
        u8d_pkg::KIND_LEAD: begin
          extra_total_next = pop_entry.extra;
          bytes_left_next  = pop_entry.extra;
          accumulated_next = u8d_pkg::CP_W'(pop_entry.payload);
        end
        default: begin
          emit               = 1'b1;
          result_next.status = u8d_pkg::ST_BAD_LEAD;
        end
      endcase
    end else if (pop_entry.kind != u8d_pkg::KIND_CONT) begin
      emit                   = 1'b1;
      result_next.status     = u8d_pkg::ST_BAD_CONT;
      result_next.byte_count = extra_total - bytes_left + 3'd1;
      bytes_left_next        = 3'd0;
      extra_total_next       = 3'd0;
      accumulated_next       = '0;
    end else if (bytes_left == 3'd1) begin
      emit                   = 1'b1;
      result_next.byte_count = extra_total + 3'd1;
      if (acc_shift <= u8d_pkg::range_top(extra_total - 3'd1)) begin
        result_next.status     = u8d_pkg::ST_OVERLONG;
      end else begin
        result_next.status     = u8d_pkg::ST_OK;
        result_next.code_point = acc_shift;
      end
      bytes_left_next  = 3'd0;
      extra_total_next = 3'd0;
      accumulated_next = '0;
    end else begin
      bytes_left_next  = bytes_left - 3'd1;
      accumulated_next = acc_shift;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left  <= 3'd0;
      extra_total <= 3'd0;
      accumulated <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (pop) begin
        bytes_left  <= bytes_left_next;
        extra_total <= extra_total_next;
        accumulated <= accumulated_next;
      end
      if (advance) begin
        m_tvalid <= pop && emit;
      end
    end
    if (pop && emit) begin
      result <= result_next;
    end
  end

endmodule
`default_nettype wire

>>> test/utf8_stream_decoder_core_test.sv
// Self-checking testbench of the UTF-8 stream decoder core: directed table, then random streams.
module utf8_stream_decoder_core_test;
  import u8d_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int ITEM_TARGET  = 1850;
  localparam int QUIET_FROM   = 1600;
  localparam int DRAIN_CYCLES = 20;
  localparam int REPORT_MAX   = 10;

  typedef struct {
    logic [7:0]      data;
    bit              fixed;
    logic [CP_W-1:0] cp;
    status_t         st;
    logic [2:0]      cnt;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;

  result_t    expected_results[$];
  logic [7:0] char_bytes[$];
  int         fail_count;
  int         sent_count;
  int         cycle_count;
  int         rx_stall;
  bit         idle_on;

  // decoder state mirror
  logic [2:0]      seq_left;
  logic [2:0]      seq_extra;
  logic [CP_W-1:0] seq_acc;

  logic [31:0] len_top [0:5] = '{32'h0000007f, 32'h000007ff, 32'h0000ffff,
                                 32'h001fffff, 32'h03ffffff, 32'h7fffffff};

  stim_row_t dir_rows [0:25] = '{
    '{8'h00, 1'b1, 31'h0,        ST_OK,       3'd1},
    '{8'h7f, 1'b1, 31'h7f,       ST_OK,       3'd1},
    '{8'h80, 1'b1, 31'h0,        ST_BAD_LEAD, 3'd0},
    '{8'hfe, 1'b1, 31'h0,        ST_BAD_LEAD, 3'd0},
    '{8'hff, 1'b1, 31'h0,        ST_BAD_LEAD, 3'd0},
    '{8'hc2, 1'b0, 31'h0,        ST_OK,       3'd0},
    '{8'ha9, 1'b0, 31'h0,        ST_OK,       3'd0},
    '{8'hc0, 1'b0, 31'h0,        ST_OK,       3'd0},
    '{8'h80, 1'b1, 31'h0,        ST_OVERLONG, 3'd2},
    '{8'he2, 1'b0, 31'h0,        ST_OK,       3'd0},
    '{8'h82, 1'b0, 31'h0,        ST_OK,       3'd0},
    '{8'hac, 1'b0, 31'h0,        ST_OK,       3'd0},
    '{8'he0, 1'b0, 31'h0,        ST_OK,       3'd0},
    '{8'h41, 1'b1, 31'h0,        ST_BAD_CONT, 3'd1},
    '{8'hfc, 1'b0, 31'h0,        ST_OK,       3'd0},
    '{8'h84, 1'b0, 31'h0,        ST_OK,       3'd0},
    '{8'h80, 1'b0, 31'h0,        ST_OK,       3'd0},
    '{8'h80, 1'b0, 31'h0,        ST_OK,       3'd0},
    '{8'h80, 1'b0, 31'h0,        ST_OK,       3'd0},
    '{8'h80, 1'b0, 31'h0,        ST_OK,       3'd0},
    '{8'hfd, 1'b0, 31'h0,        ST_OK,       3'd0},
    '{8'hbf, 1'b0, 31'h0,        ST_OK,       3'd0},
    '{8'hbf, 1'b0, 31'h0,        ST_OK,       3'd0},
    '{8'hbf, 1'b0, 31'h0,        ST_OK,       3'd0},
    '{8'hbf, 1'b0, 31'h0,        ST_OK,       3'd0},
    '{8'hbf, 1'b1, 31'h7fffffff, ST_OK,       3'd6}
  };

  utf8_stream_decoder_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  function automatic bit utf8_decode_byte(input logic [7:0] b, output result_t r);
    int          ones;
    int          k;
    logic [2:0]  len;
    ones = 0;
    k    = 0;
    r    = '{code_point: '0, status: ST_OK, byte_count: '0};
    if (seq_left == 3'd0) begin
      for (int i = 7; i >= 0 && b[i]; i--) ones++;
      if (ones == 0) begin
        r = '{code_point: CP_W'(b), status: ST_OK, byte_count: 3'd1};
        return 1'b1;
      end
      if (ones == 1 || ones > 6) begin
        r = '{code_point: '0, status: ST_BAD_LEAD, byte_count: 3'd0};
        return 1'b1;
      end
      seq_extra = 3'(ones - 1);
      seq_left  = seq_extra;
      seq_acc   = CP_W'(b & (8'h7f >> ones));
      return 1'b0;
    end
    if (b[7:6] != 2'b10) begin
      r = '{code_point: '0, status: ST_BAD_CONT, byte_count: 3'(seq_extra - seq_left + 3'd1)};
      seq_left  = '0;
      seq_extra = '0;
      seq_acc   = '0;
      return 1'b1;
    end
    seq_acc  = {seq_acc[CP_W-7:0], b[5:0]};
    seq_left = seq_left - 3'd1;
    if (seq_left != 3'd0) return 1'b0;
    len = seq_extra + 3'd1;
    while (k < 5 && {1'b0, seq_acc} > len_top[k]) k++;
    if (k != int'(len) - 1) begin
      r = '{code_point: '0, status: ST_OVERLONG, byte_count: len};
    end else begin
      r = '{code_point: seq_acc, status: ST_OK, byte_count: len};
    end
    seq_left  = '0;
    seq_extra = '0;
    seq_acc   = '0;
    return 1'b1;
  endfunction

  task automatic send_byte(input logic [7:0] b, output bit produced, output result_t r);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    sent_count++;
    produced = utf8_decode_byte(b, r);
  endtask

  // one random character: valid, overlong, broken or a noise byte
  task automatic plan_random_char();
    int          n;
    int          pick;
    int          cut;
    logic [31:0] v;
    logic [7:0]  lead_mask;
    char_bytes.delete();
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      char_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    n = $urandom_range(1, 6);
    if (n == 1) begin
      v = $urandom_range(0, 127);
    end else if (pick < 20) begin
      v = $urandom_range(0, len_top[n-2]);
    end else begin
      v = $urandom_range(len_top[n-2] + 1, len_top[n-1]);
    end
    if (n == 1) begin
      char_bytes.push_back(8'(v));
    end else begin
      lead_mask = 8'hff << (8 - n);
      char_bytes.push_back(lead_mask | 8'(v >> (6 * (n - 1))));
      for (int i = n - 2; i >= 0; i--) char_bytes.push_back(8'h80 | (8'(v >> (6 * i)) & 8'h3f));
    end
    if (pick >= 20 && pick < 32 && n > 1) begin
      cut = $urandom_range(1, n - 1);
      char_bytes[cut] = $urandom_range(0, 1) ? 8'($urandom_range(0, 127))
                                             : (8'hc0 | 8'($urandom_range(0, 63)));
      while (char_bytes.size() > cut + 1) void'(char_bytes.pop_back());
    end
  endtask

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 6) == 0) begin
      rx_stall = $urandom_range(1, 11) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.code_point = m_tdata[30:0];
      got.status     = status_t'(m_tdata[32:31]);
      got.byte_count = m_tdata[35:33];
      if (expected_results.size() == 0) begin
        if (fail_count < REPORT_MAX)
          $display("unexpected result: cp=%h st=%0d cnt=%0d",
                   got.code_point, got.status, got.byte_count);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          if (fail_count < REPORT_MAX)
            $display("mismatch: expected cp=%h st=%0d cnt=%0d, got cp=%h st=%0d cnt=%0d",
                     want.code_point, want.status, want.byte_count,
                     got.code_point, got.status, got.byte_count);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    bit      produced;
    result_t r;
    clk         = 1'b0;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = 8'h00;
    sent_count  = 0;
    idle_on     = 1'b1;
    seq_left    = '0;
    seq_extra   = '0;
    seq_acc     = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < 26; i++) begin
      send_byte(dir_rows[i].data, produced, r);
      if (dir_rows[i].fixed)
        expected_results.push_back('{code_point: dir_rows[i].cp, status: dir_rows[i].st,
                                     byte_count: dir_rows[i].cnt});
      else if (produced)
        expected_results.push_back(r);
    end

    // hold the byte side until every result has drained
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);

    while (sent_count < ITEM_TARGET) begin
      idle_on = sent_count < QUIET_FROM;
      plan_random_char();
      foreach (char_bytes[j]) begin
        send_byte(char_bytes[j], produced, r);
        if (produced) expected_results.push_back(r);
      end
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/u8d_pkg.sv
rtl/core/u8d_front.sv
rtl/core/u8d_queue.sv
rtl/core/u8d_back.sv
rtl/core/utf8_stream_decoder_core.sv
test/utf8_stream_decoder_core_test.sv
